/* rtl/core/cdr_pkg.sv */
// Shared constants and control types for the cepstral delta regression block.
// No dependencies; imported by the datapath, controller and top module.
package cdr_pkg;

  localparam int MAX_COEFFS = 32;
  localparam int COEF_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_COEFFS);
  localparam int NUM_W      = 6;   // width of the num_coeffs register
  localparam int NUM_SLOTS  = 4;
  localparam int SLOT_W     = 2;
  localparam int FRAMES_W   = 4;

  localparam logic [FRAMES_W-1:0] DELTA_START  = FRAMES_W'(4);
  localparam logic [FRAMES_W-1:0] DDELTA_START = FRAMES_W'(8);
  localparam logic [FRAMES_W-1:0] FRAMES_SAT   = FRAMES_W'(9);
  localparam logic [NUM_W-1:0]    NUM_COEFFS_RST = NUM_W'(13);
  localparam logic [NUM_W-1:0]    MAX_COEFFS_N   = NUM_W'(MAX_COEFFS);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NUM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEFFS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 1'b1;

  // Regression arithmetic: 1/sqrt(10) in unsigned Q0.24
  localparam int FRAC_W = 24;
  localparam logic [FRAC_W-1:0] INV_SQRT10_Q24 = FRAC_W'(5305422);
  localparam int N_W    = COEF_WIDTH + 3;      // signed 2*(a2-b2)+(a1-b1)
  localparam int MAG_W  = COEF_WIDTH + 2;      // its magnitude
  localparam int PROD_W = MAG_W + FRAC_W;

  // Stream payload widths
  localparam int IN_TDATA_W  = ((COEF_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 3 * COEF_WIDTH + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic              capture;  // latch the accepted item, start RAM reads
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              mode;
    logic              c_we;     // write the new coefficient into the oldest slot
    logic              ld_n;     // load regression numerator
    logic              n_dd;     // numerator from deltas instead of cepstra
    logic              ld_prod;  // load scaled magnitude
    logic              ld_dnew;  // hold new delta
    logic              d_we;     // write the new delta into the oldest slot
    logic              ld_dd;    // hold delta-delta
    logic              ld_out;   // load the output register
  } cdr_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds a result not yet taken
  } cdr_status_t;

endpackage

/* rtl/core/cdr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cdr_datapath.sv */
// Datapath: frame stores (one RAM bank per slot), shared regression unit and
// output register. Depends on cdr_pkg and cdr_ram.
module cdr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdr_pkg::cdr_cmd_t                   cmd_i,
  output cdr_pkg::cdr_status_t                status_o,
  input  logic signed [cdr_pkg::COEF_WIDTH-1:0] coef_value_i,
  output logic signed [cdr_pkg::COEF_WIDTH-1:0] cepstrum_o,
  output logic signed [cdr_pkg::COEF_WIDTH-1:0] delta_o,
  output logic signed [cdr_pkg::COEF_WIDTH-1:0] delta_delta_o,
  output logic [cdr_pkg::IDX_W-1:0]           coef_index_o,
  output logic                                last_of_frame_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i
);
  import cdr_pkg::*;

  localparam int R_W = N_W + 1;

  logic signed [COEF_WIDTH-1:0] x_q;
  logic [IDX_W-1:0]             idx_q;
  logic [SLOT_W-1:0]            slot_q;
  logic                         last_q;
  logic                         mode_q;

  logic [COEF_WIDTH-1:0]        c_rd [NUM_SLOTS];
  logic [COEF_WIDTH-1:0]        d_rd [NUM_SLOTS];
  logic signed [COEF_WIDTH-1:0] cs [NUM_SLOTS];
  logic signed [COEF_WIDTH-1:0] ds [NUM_SLOTS];

  logic signed [N_W-1:0]        n_d, n_q;
  logic signed [N_W-1:0]        diff1, diff2;
  logic signed [COEF_WIDTH-1:0] op_a2, op_a1, op_b1, op_b2;
  logic [MAG_W-1:0]             mag;
  logic [PROD_W-1:0]            prod_q;
  logic                         neg_q;
  logic [PROD_W:0]              rsum;
  logic [N_W-1:0]               qmag;
  logic signed [R_W-1:0]        rval;
  logic signed [COEF_WIDTH-1:0] rsat;
  logic                         fits;

  logic signed [COEF_WIDTH-1:0] dnew_q, dd_q;
  logic signed [COEF_WIDTH-1:0] cep_out_q, delta_out_q, dd_out_q;
  logic [IDX_W-1:0]             idx_out_q;
  logic                         last_out_q;
  logic                         out_valid_q;

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= coef_value_i;
      idx_q  <= cmd_i.idx;
      slot_q <= cmd_i.slot;
      last_q <= cmd_i.last;
      mode_q <= cmd_i.mode;
    end
  end

  // One bank per ring slot; all four banks are read at the coefficient index
  for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_bank
    cdr_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_COEFFS)
    ) u_cep_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.c_we && (slot_q == SLOT_W'(b))),
      .waddr_i (idx_q),
      .wdata_i (x_q),
      .re_i    (cmd_i.capture),
      .raddr_i (cmd_i.idx),
      .rdata_o (c_rd[b])
    );

    cdr_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_COEFFS)
    ) u_dlt_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.d_we && (slot_q == SLOT_W'(b))),
      .waddr_i (idx_q),
      .wdata_i (rsat),
      .re_i    (cmd_i.capture),
      .raddr_i (cmd_i.idx),
      .rdata_o (d_rd[b])
    );

    // Rotate so that entry 0 is the oldest frame
    assign cs[b] = c_rd[SLOT_W'(slot_q + SLOT_W'(b))];
    assign ds[b] = d_rd[SLOT_W'(slot_q + SLOT_W'(b))];
  end

  // Numerator 2*(a2-b2) + (a1-b1)
  always_comb begin
    op_a2 = cmd_i.n_dd ? dnew_q : x_q;
    op_a1 = cmd_i.n_dd ? ds[3]  : cs[3];
    op_b1 = cmd_i.n_dd ? ds[1]  : cs[1];
    op_b2 = cmd_i.n_dd ? ds[0]  : cs[0];
    diff2 = N_W'(op_a2) - N_W'(op_b2);
    diff1 = N_W'(op_a1) - N_W'(op_b1);
    n_d   = (diff2 <<< 1) + diff1;
  end

  assign mag = n_q[N_W-1] ? MAG_W'(-n_q) : MAG_W'(n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_n) begin
      n_q <= n_d;
    end
    if (cmd_i.ld_prod) begin
      prod_q <= PROD_W'(mag) * PROD_W'(INV_SQRT10_Q24);
      neg_q  <= n_q[N_W-1];
    end
  end

  // Round half away from zero, restore sign, saturate
  always_comb begin
    rsum = (PROD_W + 1)'(prod_q) + ((PROD_W + 1)'(1) << (FRAC_W - 1));
    qmag = rsum[PROD_W:FRAC_W];
    rval = neg_q ? -R_W'(qmag) : R_W'(qmag);
    fits = (rval[R_W-1:COEF_WIDTH-1] == '0) || (rval[R_W-1:COEF_WIDTH-1] == '1);
    if (fits) begin
      rsat = rval[COEF_WIDTH-1:0];
    end else if (rval[R_W-1]) begin
      rsat = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    end else begin
      rsat = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_dnew) begin
      dnew_q <= rsat;
    end
    if (cmd_i.ld_dd) begin
      dd_q <= rsat;
    end
  end

  // Output register; mode 1 aligns everything four frames back
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      cep_out_q   <= mode_q ? cs[0] : cs[2];
      delta_out_q <= mode_q ? ds[2] : dnew_q;
      dd_out_q    <= mode_q ? dd_q  : '0;
      idx_out_q   <= idx_q;
      last_out_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign cepstrum_o      = cep_out_q;
  assign delta_o         = delta_out_q;
  assign delta_delta_o   = dd_out_q;
  assign coef_index_o    = idx_out_q;
  assign last_of_frame_o = last_out_q;
  assign out_valid_o     = out_valid_q;

endmodule

/* rtl/core/cdr_ctrl.sv */
// Controller: configuration registers, frame counters and the sequencer that
// drives the datapath. Depends on cdr_pkg.
module cdr_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cdr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output cdr_pkg::cdr_cmd_t                cmd_o,
  input  cdr_pkg::cdr_status_t             status_i
);
  import cdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_D,
    ST_RND_D,
    ST_PRE_DD,
    ST_MUL_DD,
    ST_RND_DD,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [NUM_W-1:0]     num_q;
  logic                 mode_q;
  logic [IDX_W-1:0]     cnt_q;
  logic [FRAMES_W-1:0]  frames_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 has_delta_q, do_dd_q, emit_q;

  logic [NUM_W-1:0]     eff_len;
  logic [IDX_W-1:0]     cur_idx;
  logic                 cur_last;
  logic                 accept;

  always_comb begin
    if (num_q == '0) begin
      eff_len = NUM_W'(1);
    end else if (num_q > MAX_COEFFS_N) begin
      eff_len = MAX_COEFFS_N;
    end else begin
      eff_len = num_q;
    end
  end

  assign cur_idx  = (NUM_W'(cnt_q) >= eff_len) ? '0 : cnt_q;
  assign cur_last = (NUM_W'(cur_idx) == (eff_len - NUM_W'(1)));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.idx     = cur_idx;
    cmd_o.slot    = slot_q;
    cmd_o.last    = cur_last;
    cmd_o.mode    = mode_q;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.c_we = 1'b1;
        cmd_o.ld_n = has_delta_q;
        state_d    = has_delta_q ? ST_MUL_D : ST_IDLE;
      end
      ST_MUL_D: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = ST_RND_D;
      end
      ST_RND_D: begin
        cmd_o.ld_dnew = 1'b1;
        cmd_o.d_we    = 1'b1;
        if (do_dd_q) begin
          state_d = ST_PRE_DD;
        end else if (emit_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PRE_DD: begin
        cmd_o.ld_n = 1'b1;
        cmd_o.n_dd = 1'b1;
        state_d    = ST_MUL_DD;
      end
      ST_MUL_DD: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = ST_RND_DD;
      end
      ST_RND_DD: begin
        cmd_o.ld_dd = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= NUM_COEFFS_RST;
      mode_q      <= 1'b0;
      cnt_q       <= '0;
      frames_q    <= '0;
      slot_q      <= '0;
      has_delta_q <= 1'b0;
      do_dd_q     <= 1'b0;
      emit_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_COEFFS: num_q  <= cfg_wdata_i[NUM_W-1:0];
          CFG_MODE:       mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
        // any write restarts the stream
        cnt_q    <= '0;
        frames_q <= '0;
        slot_q   <= '0;
      end else if (accept) begin
        has_delta_q <= (frames_q >= DELTA_START);
        do_dd_q     <= mode_q && (frames_q >= DDELTA_START);
        emit_q      <= (frames_q >= DELTA_START) && (!mode_q || (frames_q >= DDELTA_START));
        if (cur_last) begin
          cnt_q  <= '0;
          slot_q <= slot_q + SLOT_W'(1);
          if (frames_q < FRAMES_SAT) begin
            frames_q <= frames_q + FRAMES_W'(1);
          end
        end else begin
          cnt_q <= cur_idx + IDX_W'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_frames_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FRAMES_SAT)
    else $error("frame count beyond saturation");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> !status_i.out_busy)
    else $error("output register overwritten before taken");

  a_dd_needs_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE_DD) |-> (has_delta_q && emit_q && $past(state_q) == ST_RND_D))
    else $error("delta-delta pass without a delta");
`endif

endmodule

/* rtl/core/cepstral_delta_regression.sv */
// Cepstral delta / delta-delta regression over a window of two frames on each side.
// A new coefficient is accepted only when the previous one is finished: before
// the fifth frame that is the store write alone; from it a delta pass follows,
// and in mode 1 from the ninth frame a delta-delta pass too, both through the
// shared regression multiplier; a stalled output delays the next accept.
// Reset: counters and ring pointer clear, num_coeffs 13, mode 0; stores unset.
module cepstral_delta_regression (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cdr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cdr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // coef_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cepstrum, delta, delta_delta, coef_index, zero pad
  output logic [cdr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast   // last_of_frame
);
  import cdr_pkg::*;

  cdr_cmd_t                     cmd;
  cdr_status_t                  status;
  logic signed [COEF_WIDTH-1:0] cepstrum, delta, delta_delta;
  logic [IDX_W-1:0]             coef_index;

  cdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cdr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .coef_value_i    (s_axis_tdata[COEF_WIDTH-1:0]),
    .cepstrum_o      (cepstrum),
    .delta_o         (delta),
    .delta_delta_o   (delta_delta),
    .coef_index_o    (coef_index),
    .last_of_frame_o (m_axis_tlast),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = OUT_TDATA_W'({coef_index, delta_delta, delta, cepstrum});

endmodule
